FILE: src/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

  // Pixel channel and result widths.
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 8;

  // Hue is kept in 1/64 degree, so one 60 degree sector is 3840 units.
  localparam logic [11:0]      HUE_SECTOR = 12'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam logic [7:0]       CHAN_MAX   = 8'd255;

  // Dividend widths: hue numerator reaches 6 * 3840 * 255 + 127, saturation
  // numerator reaches 255 * 255 + 127.
  localparam int HUE_NUM_W = 23;
  localparam int SAT_NUM_W = 16;

  // Sector base in units of one sector times chroma.
  localparam int BASE_W = 3;
  localparam logic [BASE_W-1:0] BASE_RED      = 3'd0;
  localparam logic [BASE_W-1:0] BASE_GREEN    = 3'd2;
  localparam logic [BASE_W-1:0] BASE_BLUE     = 3'd4;
  localparam logic [BASE_W-1:0] BASE_RED_WRAP = 3'd6;

  // Load enables for the three register stages of the divider.
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
  } div_ctl_t;

endpackage

`default_nettype wire

FILE: src/rgbhsv_div.sv
`default_nettype none

// Three-stage divider by an 8-bit divisor: reciprocal lookup, multiply,
// back-multiply, then a single correction step in the output logic.
// The reciprocal floor((2^(NUM_W+1) - 1) / den) leaves the estimate at most
// one below the true quotient for any dividend below 2^NUM_W.
module rgbhsv_div import rgbhsv_pkg::*; #(
  parameter int NUM_W = HUE_NUM_W,
  parameter int QUO_W = HUE_W
) (
  input  wire logic             clk,
  input  wire div_ctl_t         ctl,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [CHAN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int DEPTH  = 2 ** CHAN_W;
  localparam int QD_W   = QUO_W + CHAN_W;

  logic [RCP_W-1:0] rcp_tab [DEPTH];

  // Divisor zero never yields a used quotient; its entry is left at zero.
  assign rcp_tab[0] = '0;
  for (genvar i = 1; i < DEPTH; i++) begin : g_rcp
    localparam logic [RCP_W-1:0] RV =
      RCP_W'(((64'd1 << RCP_W) - 64'd1) / 64'(i));
    assign rcp_tab[i] = RV;
  end

  logic [NUM_W-1:0]  num_a_r, num_b_r, num_c_r;
  logic [CHAN_W-1:0] den_a_r, den_b_r, den_c_r;
  logic [RCP_W-1:0]  rcp_a_r;
  logic [PROD_W-1:0] prod_b_r, prod_nxt;
  logic [QUO_W-1:0]  qest_c_r, qest_nxt;
  logic [NUM_W-1:0]  qd_c_r, qd_nxt;
  logic [QD_W-1:0]   qd_full;
  logic [NUM_W-1:0]  rem;

  assign prod_nxt = PROD_W'(num_a_r) * PROD_W'(rcp_a_r);
  assign qest_nxt = QUO_W'(prod_b_r[PROD_W-1:RCP_W]);
  assign qd_full  = QD_W'(qest_nxt) * QD_W'(den_b_r);
  assign qd_nxt   = NUM_W'(qd_full);

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      num_a_r <= num;
      den_a_r <= den;
      rcp_a_r <= rcp_tab[den];
    end
    if (ctl.en_b) begin
      prod_b_r <= prod_nxt;
      num_b_r  <= num_a_r;
      den_b_r  <= den_a_r;
    end
    if (ctl.en_c) begin
      qest_c_r <= qest_nxt;
      qd_c_r   <= qd_nxt;
      num_c_r  <= num_b_r;
      den_c_r  <= den_b_r;
    end
  end

  // The remainder stays below twice the divisor, so one compare settles it.
  assign rem = num_c_r - qd_c_r;
  assign quo = (rem >= NUM_W'(den_c_r)) ? qest_c_r + QUO_W'(1) : qest_c_r;

endmodule

`default_nettype wire

FILE: src/rgb_to_hsv_convert_top.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall   in_red_in, in_green_in, in_blue_in (8 b)
// out_     output     out_valid / out_stall out_hue_out (15 b), out_sat_out, out_val_out (8 b)
//
// One pixel is taken per clock cycle while the input is not stalled; each result
// passes stage 0, the divider stages and the output register. The depth is set
// by the two divider chains, which need a reciprocal lookup, a wide multiply and
// a back-multiply before correction.
// Synchronous active-low reset clears only the stage valid bits.
// A stall on the output holds the last stage; empty stages further up keep
// filling, so the input is stalled only once every stage holds a pixel.
module rgb_to_hsv_convert_top import rgbhsv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAN_W-1:0] in_red_in,
  input  wire logic [CHAN_W-1:0] in_green_in,
  input  wire logic [CHAN_W-1:0] in_blue_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [HUE_W-1:0]       out_hue_out,
  output logic [SAT_W-1:0]       out_sat_out,
  output logic [CHAN_W-1:0]      out_val_out
);

  localparam int NSTG = 5;

  // Stage 0 holds max, chroma and sector, stages 1 to 3 are the dividers,
  // stage 4 is the output register.
  logic [NSTG-1:0] vld_r, vld_nxt, free;

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    free[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      free[i] = !vld_r[i] || free[i+1];
    end
    if (free[0]) begin
      vld_nxt[0] = in_valid;
    end else begin
      vld_nxt[0] = vld_r[0];
    end
    for (int i = 1; i < NSTG; i++) begin
      if (free[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !free[0];
  assign out_valid = vld_r[NSTG-1];

  // Stage 0: largest and smallest channel, sector choice with red first,
  // then green, then blue, and the signed channel difference of that sector.
  logic [CHAN_W-1:0]       mx_nxt, mn_nxt;
  logic [BASE_W-1:0]       base_nxt;
  logic signed [CHAN_W:0]  x_nxt;

  always_comb begin
    mx_nxt = in_red_in;
    mn_nxt = in_red_in;
    if (in_green_in > mx_nxt) mx_nxt = in_green_in;
    if (in_blue_in > mx_nxt)  mx_nxt = in_blue_in;
    if (in_green_in < mn_nxt) mn_nxt = in_green_in;
    if (in_blue_in < mn_nxt)  mn_nxt = in_blue_in;

    priority if (in_red_in >= in_green_in && in_red_in >= in_blue_in) begin
      x_nxt    = $signed({1'b0, in_green_in}) - $signed({1'b0, in_blue_in});
      base_nxt = x_nxt[CHAN_W] ? BASE_RED_WRAP : BASE_RED;
    end else if (in_green_in >= in_blue_in) begin
      x_nxt    = $signed({1'b0, in_blue_in}) - $signed({1'b0, in_red_in});
      base_nxt = BASE_GREEN;
    end else begin
      x_nxt    = $signed({1'b0, in_red_in}) - $signed({1'b0, in_green_in});
      base_nxt = BASE_BLUE;
    end
  end

  logic [CHAN_W-1:0]      mx0_r, d0_r;
  logic [BASE_W-1:0]      base0_r;
  logic signed [CHAN_W:0] x0_r;

  always_ff @(posedge clk) begin
    if (free[0] && in_valid) begin
      mx0_r   <= mx_nxt;
      d0_r    <= mx_nxt - mn_nxt;
      base0_r <= base_nxt;
      x0_r    <= x_nxt;
    end
  end

  // Dividends. Hue: (base * d + x) sectors plus half the chroma for rounding,
  // so the quotient by d is the rounded hue. Saturation: 255 * d plus half
  // the maximum, divided by the maximum.
  logic [10:0]          kd;
  logic signed [11:0]   tsum;
  logic [10:0]          tpos;
  logic [HUE_NUM_W-1:0] num_h;
  logic [SAT_NUM_W-1:0] num_s;

  assign kd    = 11'(base0_r) * 11'(d0_r);
  assign tsum  = $signed({1'b0, kd}) + $signed({{3{x0_r[CHAN_W]}}, x0_r});
  assign tpos  = tsum[10:0];
  assign num_h = HUE_NUM_W'(tpos) * HUE_NUM_W'(HUE_SECTOR) + HUE_NUM_W'(d0_r >> 1);
  assign num_s = SAT_NUM_W'(d0_r) * SAT_NUM_W'(CHAN_MAX) + SAT_NUM_W'(mx0_r >> 1);

  div_ctl_t div_ctl;
  assign div_ctl.en_a = free[1] && vld_r[0];
  assign div_ctl.en_b = free[2] && vld_r[1];
  assign div_ctl.en_c = free[3] && vld_r[2];

  logic [HUE_W-1:0] quo_h;
  logic [SAT_W-1:0] quo_s;

  rgbhsv_div #(
    .NUM_W (HUE_NUM_W),
    .QUO_W (HUE_W)
  ) u_div_hue (
    .clk (clk),
    .ctl (div_ctl),
    .num (num_h),
    .den (d0_r),
    .quo (quo_h)
  );

  rgbhsv_div #(
    .NUM_W (SAT_NUM_W),
    .QUO_W (SAT_W)
  ) u_div_sat (
    .clk (clk),
    .ctl (div_ctl),
    .num (num_s),
    .den (mx0_r),
    .quo (quo_s)
  );

  // Value and the grey flag ride alongside the divider stages.
  logic [CHAN_W-1:0] mx1_r, mx2_r, mx3_r;
  logic              grey1_r, grey2_r, grey3_r;

  always_ff @(posedge clk) begin
    if (div_ctl.en_a) begin
      mx1_r   <= mx0_r;
      grey1_r <= (d0_r == '0);
    end
    if (div_ctl.en_b) begin
      mx2_r   <= mx1_r;
      grey2_r <= grey1_r;
    end
    if (div_ctl.en_c) begin
      mx3_r   <= mx2_r;
      grey3_r <= grey2_r;
    end
  end

  // Output stage: a grey pixel has hue 0, a full turn wraps to 0, and a
  // black pixel has saturation 0 in place of the quotient by its zero divisor.
  logic [HUE_W-1:0]  hue_nxt;
  logic [SAT_W-1:0]  sat_nxt;

  assign hue_nxt = (grey3_r || quo_h == HUE_FULL) ? '0 : quo_h;
  assign sat_nxt = (mx3_r == '0) ? '0 : quo_s;

  logic [HUE_W-1:0]  hue_r;
  logic [SAT_W-1:0]  sat_r;
  logic [CHAN_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (free[4] && vld_r[3]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= mx3_r;
    end
  end

  assign out_hue_out = hue_r;
  assign out_sat_out = sat_r;
  assign out_val_out = val_r;

  // The hue never reaches a full turn after the wrap.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_out < HUE_FULL)
    else $error("hue result out of range");

  // A black pixel carries neither hue nor saturation.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_val_out == '0 |-> out_sat_out == '0 && out_hue_out == '0)
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation means zero chroma, hence hue zero as well.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat_out == '0 |-> out_hue_out == '0)
    else $error("unsaturated pixel with nonzero hue");

  // The input is held off only when every stage holds a pixel and the
  // output is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r == '1 && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

// Self-checking bench for the RGB to hexcone HSV converter.
module testbench import rgbhsv_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // One pixel waiting to be offered. The gap is the number of idle cycles the
  // sender spends before offering it. When drain is set, the sender also holds
  // the pixel back until every result that is still due has come out.
  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    int unsigned       gap;
    bit                drain;
  } pixel_t;

  // One converted pixel, at the widths of the result ports.
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [CHAN_W-1:0] val;
  } hsv_t;

  localparam int unsigned SECTOR_UNITS = 3840;
  localparam int unsigned CIRCLE_UNITS = 23040;
  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned RANDOM_PIXELS = 1750;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAN_W-1:0] in_red_in = '0;
  logic [CHAN_W-1:0] in_green_in = '0;
  logic [CHAN_W-1:0] in_blue_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [HUE_W-1:0]  out_hue_out;
  logic [SAT_W-1:0]  out_sat_out;
  logic [CHAN_W-1:0] out_val_out;

  rgb_to_hsv_convert_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hue_out (out_hue_out),
    .out_sat_out (out_sat_out),
    .out_val_out (out_val_out)
  );

  // 4 ns clock period, 2 ns high and 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_t pixel_queue[$];
  hsv_t   hsv_expected[$];

  // Transfer flags, captured at the rising edge and read by the driver and the
  // receiver at the following falling edge.
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  int unsigned mismatches = 0;
  int unsigned pixels_in = 0;
  int unsigned results_out = 0;
  int unsigned grey_pixels = 0;
  int unsigned tied_pixels = 0;
  int unsigned long_holds = 0;

  // Hexcone conversion in exact integer arithmetic. The hue is built as a
  // non-negative numerator over the chroma, then rounded to nearest with halves
  // going up. Red wins a tie for the maximum, then green, then blue.
  function automatic hsv_t hexcone_hsv(logic [CHAN_W-1:0] r8, logic [CHAN_W-1:0] g8,
                                       logic [CHAN_W-1:0] b8);
    int unsigned r, g, b, top, bottom, chroma, numer, hue, sat;
    hsv_t res;
    r = r8;
    g = g8;
    b = b8;
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    chroma = top - bottom;
    hue = 0;
    sat = 0;
    if (chroma != 0) begin
      if (top == r) begin
        // A negative red-sector hue is wrapped by adding the full circle.
        if (g >= b) numer = SECTOR_UNITS * (g - b);
        else numer = CIRCLE_UNITS * chroma - SECTOR_UNITS * (b - g);
      end else if (top == g) begin
        if (b >= r) numer = 2 * SECTOR_UNITS * chroma + SECTOR_UNITS * (b - r);
        else numer = 2 * SECTOR_UNITS * chroma - SECTOR_UNITS * (r - b);
      end else begin
        if (r >= g) numer = 4 * SECTOR_UNITS * chroma + SECTOR_UNITS * (r - g);
        else numer = 4 * SECTOR_UNITS * chroma - SECTOR_UNITS * (g - r);
      end
      hue = (2 * numer + chroma) / (2 * chroma);
      if (hue >= CIRCLE_UNITS) hue = hue - CIRCLE_UNITS;
    end
    // A black pixel has no saturation and takes no division.
    if (top != 0) sat = (2 * chroma * FULL_SCALE + top) / (2 * top);
    res.hue = hue[HUE_W-1:0];
    res.sat = sat[SAT_W-1:0];
    res.val = top[CHAN_W-1:0];
    return res;
  endfunction

  // Prints one line per mismatch and keeps the count; the printout is capped so
  // that a broken design cannot flood the log.
  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH @%0t result %0d: %s got %0d, wanted %0d",
               $realtime, results_out, what, got, want);
  endtask

  task automatic queue_pixel(int unsigned r, int unsigned g, int unsigned b,
                             int unsigned gap, bit drain);
    pixel_t p;
    p.red = r[CHAN_W-1:0];
    p.green = g[CHAN_W-1:0];
    p.blue = b[CHAN_W-1:0];
    p.gap = gap;
    p.drain = drain;
    pixel_queue.push_back(p);
  endtask

  // Monitor. On every rising edge it records an input transfer by computing the
  // conversion the block must produce for it, and it checks an output transfer
  // against the oldest of those conversions, field by field. The result cannot
  // belong to an input taken at the same edge, so the order of the two is safe.
  always @(posedge clk) begin
    hsv_t want;
    logic [CHAN_W-1:0] hi, lo;
    if (!rst_n) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        want = hexcone_hsv(in_red_in, in_green_in, in_blue_in);
        hsv_expected.push_back(want);
        pixels_in++;
        hi = want.val;
        lo = in_red_in;
        if (in_green_in < lo) lo = in_green_in;
        if (in_blue_in < lo) lo = in_blue_in;
        if (hi == lo) grey_pixels++;
        else if ((in_red_in == hi) + (in_green_in == hi) + (in_blue_in == hi) > 1)
          tied_pixels++;
      end
      if (out_valid && !out_stall) begin
        results_out++;
        if (hsv_expected.size() == 0) begin
          flag_mismatch("unexpected result, hue", out_hue_out, 0);
        end else begin
          want = hsv_expected.pop_front();
          if (out_hue_out !== want.hue) flag_mismatch("hue", out_hue_out, want.hue);
          if (out_sat_out !== want.sat) flag_mismatch("saturation", out_sat_out, want.sat);
          if (out_val_out !== want.val) flag_mismatch("value", out_val_out, want.val);
        end
      end
    end
  end

  // Driver. At each falling edge, once the current pixel has been transferred
  // (or nothing is on offer), it counts down the next pixel's gap and then
  // offers it. With a zero gap the valid simply stays high, so back-to-back
  // transfers never see valid dropped and raised within one time step. A pixel
  // marked for draining waits until no result is outstanding.
  int unsigned gap_count = 0;
  pixel_t      next_pixel;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pixel_queue.size() != 0 &&
          !(pixel_queue[0].drain && hsv_expected.size() != 0)) begin
        if (gap_count >= pixel_queue[0].gap) begin
          next_pixel = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_red_in <= next_pixel.red;
          in_green_in <= next_pixel.green;
          in_blue_in <= next_pixel.blue;
          gap_count = 0;
        end else begin
          in_valid <= 1'b0;
          gap_count++;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. After each result it draws a number of stall cycles; every third
  // stretch of 150 results runs with no stall at all. Twice in the run it holds
  // off for a long stretch while the sender keeps offering, so the pipeline
  // fills and the block has to stall its input.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_count = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        rx_count++;
        if (rx_count == 300 || rx_count == 1200) begin
          hold_left = LONG_HOLD;
          long_holds++;
        end
        stall_left = ((rx_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 9);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: reset, a directed set of corner pixels, then random pixels.
  initial begin
    int unsigned pick, r, g, b, m, gap, blk;
    int unsigned corner[5];

    corner = '{0, 1, 254, 255, 128};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Black, white and a mid grey: no hue, no saturation.
    queue_pixel(0, 0, 0, 0, 1'b0);
    queue_pixel(255, 255, 255, 0, 1'b0);
    queue_pixel(128, 128, 128, 0, 1'b0);
    // Pure primaries and the smallest nonzero red.
    queue_pixel(255, 0, 0, 0, 1'b0);
    queue_pixel(0, 255, 0, 0, 1'b0);
    queue_pixel(0, 0, 255, 0, 1'b0);
    queue_pixel(1, 0, 0, 0, 1'b0);
    // Tied maxima: red beats green and blue, green beats blue.
    queue_pixel(255, 255, 0, 0, 1'b0);
    queue_pixel(255, 0, 255, 0, 1'b0);
    queue_pixel(0, 255, 255, 0, 1'b0);
    queue_pixel(1, 1, 0, 0, 1'b0);
    // Red sector with blue above green, so the hue wraps below 360 degrees.
    queue_pixel(255, 0, 1, 0, 1'b0);
    queue_pixel(200, 10, 150, 0, 1'b0);
    // Hue close to the sector boundaries on both sides.
    queue_pixel(255, 1, 0, 0, 1'b0);
    queue_pixel(254, 255, 0, 0, 1'b0);
    queue_pixel(0, 1, 255, 0, 1'b0);
    queue_pixel(255, 0, 254, 0, 1'b0);
    // Saturation that lands exactly on a half and rounds up.
    queue_pixel(2, 1, 1, 0, 1'b0);
    // A few ordinary colors in each sector, with descending and ascending minor.
    queue_pixel(200, 100, 50, 0, 1'b0);
    queue_pixel(50, 100, 200, 0, 1'b0);
    queue_pixel(10, 200, 100, 0, 1'b0);
    queue_pixel(100, 200, 10, 0, 1'b0);
    queue_pixel(150, 50, 250, 0, 1'b0);

    for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
      blk = i / 100;
      gap = (blk % 3 == 1) ? 0 : $urandom_range(0, 9);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end else if (pick < 70) begin
        // Grey or nearly grey, where the chroma is zero or one.
        m = $urandom_range(0, 254);
        r = m + $urandom_range(0, 1);
        g = m + $urandom_range(0, 1);
        b = m + $urandom_range(0, 1);
      end else if (pick < 85) begin
        // Two channels share the maximum.
        m = $urandom_range(0, 255);
        r = m;
        g = m;
        b = $urandom_range(0, m);
        case ($urandom_range(0, 2))
          0: begin
            g = b;
            b = m;
          end
          1: begin
            r = b;
            b = m;
          end
          default: begin
          end
        endcase
      end else begin
        r = corner[$urandom_range(0, 4)];
        g = corner[$urandom_range(0, 4)];
        b = corner[$urandom_range(0, 4)];
      end
      queue_pixel(r, g, b, gap, (i == 0 || i == 1000));
    end

    // Wait until the last pixel is transferred and every result has arrived,
    // then leave room for anything unexpected to come out.
    while (pixel_queue.size() != 0 || in_valid) @(negedge clk);
    while (hsv_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d grey, %0d with tied maxima) and checked %0d results.",
             pixels_in, grey_pixels, tied_pixels, results_out);
    $display("Output held off %0d times for long stretches; %0d mismatches found.",
             long_holds, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every gap and stall at
  // its longest.
  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding.", hsv_expected.size());
    $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire
